### hdl/bpdm_pkg.sv
// Package for the balance PD drive mixer: field widths, register indexes,
// fixed-point constants and the symmetric clamp function.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bpdm_pkg;

    // Field widths.
    localparam int ANGLE_WIDTH = 16;
    localparam int STEER_W     = 16;
    localparam int DRIVE_W     = 16;
    localparam int GAIN_W      = 20;
    localparam int FRIC_W      = 15;
    localparam int LIMIT_W     = 15;
    localparam int BIAS_W      = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SET_POINT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ENABLE = 3'd5;

    // Reset values of the registers.
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 20'd5120;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd9900;

    // The stored set point is the written value divided by ten. The quotient
    // is formed as (|x| * 52429) >> 19, which is exact for every |x| up to 32768.
    localparam logic [15:0] BIAS_RECIP = 16'd52429;
    localparam int BIAS_SHIFT = 19;
    localparam int BIAS_PROD_W = 31;
    localparam int BIAS_Q_W = 13;

    // Gain products carry a 12-bit fraction (Q.8 angle times Q.4 gain).
    localparam int FRAC_SHIFT = 12;

    // Datapath widths that follow from the angle width.
    localparam int ERR_W   = ANGLE_WIDTH + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int PP_W    = ERR_W + GAIN_W + 1;
    localparam int PD_W    = DIFF_W + GAIN_W + 1;
    localparam int ACC_W   = PD_W + 1;
    localparam int VAL_W   = ACC_W - FRAC_SHIFT;
    localparam int CLAMP_W = VAL_W + 1;

    // Pipeline depth from the input register to the result register.
    localparam int NUM_STG = 5;

    // Packed stream widths, filled up to whole bytes.
    localparam int S_TDATA_W = ((ANGLE_WIDTH + STEER_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * DRIVE_W + 7) / 8) * 8;

    // Clamp a signed value to [-lim, +lim] and return it at drive width.
    function automatic logic signed [DRIVE_W-1:0] clamp_sym(
        input logic signed [CLAMP_W-1:0] v,
        input logic [LIMIT_W-1:0]        lim
    );
        logic signed [CLAMP_W-1:0] pos;
        logic signed [CLAMP_W-1:0] neg;
        logic signed [CLAMP_W-1:0] res;
        pos = $signed({{(CLAMP_W-LIMIT_W){1'b0}}, lim});
        neg = -pos;
        if (v > pos) begin
            res = pos;
        end else if (v < neg) begin
            res = neg;
        end else begin
            res = v;
        end
        return res[DRIVE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/balance_pd_drive_mixer.sv
// Top level of the balance PD drive mixer: a five-stage streaming pipeline
// with its configuration registers and the stored last error.
// Depends on bpdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// s_        in         s_tvalid / s_tready      s_tdata: pitch_angle, steer_term
// m_        out        m_tvalid / m_tready      m_tdata: balance, left, right drive
// cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One word is accepted per cycle while s_tready is high. The first of five
// register stages loads at the edge that accepts a word; the products, the
// truncation and the clamps are spread over the stages.
// Reset is synchronous and active low; it restores the register defaults,
// clears the last error and empties the pipeline.
// A stalled output holds its word while the stages behind it keep filling,
// so s_tready falls only once every stage holds a word.
// Configuration writes are taken in every cycle.
module balance_pd_drive_mixer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [15:0] pitch_angle, [31:16] steer_term
    input  wire logic [bpdm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [15:0] balance_drive, [31:16] left_drive, [47:32] right_drive
    output logic [bpdm_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bpdm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bpdm_pkg::*;

    // Configuration registers. The set point is stored already divided by ten.
    logic [GAIN_W-1:0]            prop_gain_reg;
    logic [GAIN_W-1:0]            deriv_gain_reg;
    logic [FRIC_W-1:0]            friction_reg;
    logic signed [BIAS_Q_W-1:0]   bias_q_reg;
    logic [LIMIT_W-1:0]           limit_reg;
    logic                         enable_reg;

    logic signed [BIAS_W-1:0]     bias_raw;
    logic [BIAS_W:0]              bias_mag;
    logic [BIAS_PROD_W-1:0]       bias_prod;
    logic [BIAS_Q_W-1:0]          bias_quot;
    logic signed [BIAS_Q_W-1:0]   bias_q_next;
    logic                         cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Divide the signed set point by ten with truncation toward zero:
    // work on the magnitude and put the sign back afterwards.
    always_comb begin
        bias_raw    = $signed(cfg_data[BIAS_W-1:0]);
        bias_mag    = bias_raw[BIAS_W-1] ? (~{bias_raw[BIAS_W-1], bias_raw} + 1'b1)
                                         : {bias_raw[BIAS_W-1], bias_raw};
        bias_prod   = BIAS_PROD_W'(bias_mag) * BIAS_PROD_W'(BIAS_RECIP);
        bias_quot   = {1'b0, bias_prod[BIAS_SHIFT+BIAS_Q_W-2:BIAS_SHIFT]};
        bias_q_next = bias_raw[BIAS_W-1] ? $signed(BIAS_Q_W'(0) - bias_quot)
                                         : $signed(bias_quot);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= PROP_GAIN_RST;
            deriv_gain_reg <= '0;
            friction_reg   <= '0;
            bias_q_reg     <= '0;
            limit_reg      <= DRIVE_LIMIT_RST;
            enable_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN:    prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:   deriv_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_FRICTION:     friction_reg   <= cfg_data[FRIC_W-1:0];
                REG_SET_POINT:    bias_q_reg     <= bias_q_next;
                REG_DRIVE_LIMIT:  limit_reg      <= cfg_data[LIMIT_W-1:0];
                REG_MOTOR_ENABLE: enable_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it moves on in the same cycle.
    logic [NUM_STG-1:0] vld_reg;
    logic [NUM_STG-1:0] vld_next;
    logic [NUM_STG:0]   stg_ready;
    logic [NUM_STG-1:0] load;

    always_comb begin
        stg_ready[NUM_STG] = m_tready;
        for (int k = NUM_STG - 1; k >= 0; k--) begin
            stg_ready[k] = !vld_reg[k] || stg_ready[k+1];
        end
        for (int k = 0; k < NUM_STG; k++) begin
            if (k == 0) begin
                load[k] = s_tvalid && stg_ready[k];
            end else begin
                load[k] = vld_reg[k-1] && stg_ready[k];
            end
            vld_next[k] = load[k] || (vld_reg[k] && !stg_ready[k+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = stg_ready[0];
    assign m_tvalid = vld_reg[NUM_STG-1];

    // Stage 1: error against the set point and its change since the last word.
    // The last error follows every accepted word, whether or not the motors
    // are enabled.
    logic signed [ANGLE_WIDTH-1:0] angle_in;
    logic signed [STEER_W-1:0]     steer_in;
    logic signed [ERR_W-1:0]       err_next;
    logic signed [DIFF_W-1:0]      diff_next;
    logic signed [ERR_W-1:0]       last_err_reg;
    logic signed [ERR_W-1:0]       err_reg;
    logic signed [DIFF_W-1:0]      diff_reg;
    logic signed [STEER_W-1:0]     steer1_reg;

    always_comb begin
        angle_in  = $signed(s_tdata[ANGLE_WIDTH-1:0]);
        steer_in  = $signed(s_tdata[ANGLE_WIDTH+STEER_W-1:ANGLE_WIDTH]);
        err_next  = ERR_W'(bias_q_reg) - ERR_W'(angle_in);
        diff_next = DIFF_W'(err_next) - DIFF_W'(last_err_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
        end else if (load[0]) begin
            last_err_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            err_reg    <= err_next;
            diff_reg   <= diff_next;
            steer1_reg <= steer_in;
        end
    end

    // Stage 2: the two gain products.
    logic signed [PP_W-1:0]    pp_next;
    logic signed [PD_W-1:0]    pd_next;
    logic signed [PP_W-1:0]    pp_reg;
    logic signed [PD_W-1:0]    pd_reg;
    logic signed [STEER_W-1:0] steer2_reg;

    always_comb begin
        pp_next = PP_W'(err_reg) * PP_W'($signed({1'b0, prop_gain_reg}));
        pd_next = PD_W'(diff_reg) * PD_W'($signed({1'b0, deriv_gain_reg}));
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            pp_reg     <= pp_next;
            pd_reg     <= pd_next;
            steer2_reg <= steer1_reg;
        end
    end

    // Stage 3: sum of the products, truncated toward zero to drive units.
    // A negative sum is biased up by one less than the divisor before the
    // arithmetic shift.
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [VAL_W-1:0]   val_next;
    logic signed [VAL_W-1:0]   val_reg;
    logic signed [STEER_W-1:0] steer3_reg;

    always_comb begin
        acc      = ACC_W'(pp_reg) + ACC_W'(pd_reg);
        acc_rnd  = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_SHIFT) - 1) : ACC_W'(0));
        val_next = $signed(acc_rnd[ACC_W-1:FRAC_SHIFT]);
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            val_reg    <= val_next;
            steer3_reg <= steer2_reg;
        end
    end

    // Stage 4: friction offset pushes away from zero; zero itself counts as
    // not positive and gets the offset subtracted. Then the balance clamp.
    logic signed [CLAMP_W-1:0]  fric_ext;
    logic signed [CLAMP_W-1:0]  fv;
    logic signed [DRIVE_W-1:0]  bal_next;
    logic signed [DRIVE_W-1:0]  bal_reg;
    logic signed [STEER_W-1:0]  steer4_reg;

    always_comb begin
        fric_ext = $signed({{(CLAMP_W-FRIC_W){1'b0}}, friction_reg});
        if (val_reg > 0) begin
            fv = CLAMP_W'(val_reg) + fric_ext;
        end else begin
            fv = CLAMP_W'(val_reg) - fric_ext;
        end
        bal_next = clamp_sym(fv, limit_reg);
    end

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            bal_reg    <= bal_next;
            steer4_reg <= steer3_reg;
        end
    end

    // Stage 5: mix in the steering term for both motors and gate them with
    // the enable. The balance drive itself is passed regardless of enable.
    logic signed [DRIVE_W:0]   left_sum;
    logic signed [DRIVE_W:0]   right_sum;
    logic signed [DRIVE_W-1:0] left_next;
    logic signed [DRIVE_W-1:0] right_next;
    logic [M_TDATA_W-1:0]      out_reg;

    always_comb begin
        left_sum  = (DRIVE_W+1)'(bal_reg) + (DRIVE_W+1)'(steer4_reg);
        right_sum = (DRIVE_W+1)'(bal_reg) - (DRIVE_W+1)'(steer4_reg);
        if (enable_reg) begin
            left_next  = clamp_sym(CLAMP_W'(left_sum), limit_reg);
            right_next = clamp_sym(CLAMP_W'(right_sum), limit_reg);
        end else begin
            left_next  = '0;
            right_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            out_reg <= {right_next, left_next, bal_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

### hdl/bpdm_checker.sv
// Port-level checker for the balance PD drive mixer and its bind statement.
// Depends on bpdm_pkg and on the port list of balance_pd_drive_mixer.
`timescale 1ns / 1ps
`default_nettype none

module bpdm_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [bpdm_pkg::M_TDATA_W-1:0]   m_tdata
);
    import bpdm_pkg::*;

    localparam logic [DRIVE_W-1:0] MOST_NEG = {1'b1, {(DRIVE_W-1){1'b0}}};

    // A held output word keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // With the output register empty, no stage can be blocked.
    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // The clamps never let a drive reach the most negative code.
    a_clamp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0 +: DRIVE_W] != MOST_NEG)
                     && (m_tdata[DRIVE_W +: DRIVE_W] != MOST_NEG)
                     && (m_tdata[2*DRIVE_W +: DRIVE_W] != MOST_NEG))
        else $error("drive outside the symmetric range");

endmodule

bind balance_pd_drive_mixer bpdm_checker u_bpdm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire
